// File: hw/rtl/css_pkg.sv
// Shared types and constants for the chroma spill suppressor.
// No dependencies; compiled first.
package css_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned WeightW = 17;
  localparam int unsigned GainW   = 20;
  localparam int unsigned BrightW = 17;
  localparam int unsigned GsumW   = GainW + 1;
  localparam int unsigned FactorW = 33;
  localparam int unsigned SpillW  = 40;
  localparam int unsigned SpillFrac = 32;
  localparam int unsigned ProdFrac  = 44;
  localparam int unsigned SplitW    = 20;
  localparam int unsigned PartW     = 42;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 20;

  localparam logic [WeightW-1:0] Q16One = 17'd65536;

  localparam logic ScreenBlue = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCREEN_TYPE  = 3'd0,
    REG_ALPHA_ENABLE = 3'd1,
    REG_SPILL_MIX    = 3'd2,
    REG_SPILL_EXPAND = 3'd3,
    REG_RED_GAIN     = 3'd4,
    REG_GREEN_GAIN   = 3'd5,
    REG_BLUE_GAIN    = 3'd6,
    REG_BRIGHT_GAIN  = 3'd7
  } css_reg_e;

  // Load enables for the two stages that live inside each channel unit.
  typedef struct packed {
    logic ld3;
    logic ld4;
  } css_adv_t;

endpackage

// File: hw/rtl/css_in_if.sv
// Request channel that carries one input RGBA pixel.
// Depends on css_pkg for the channel width.
interface css_in_if;
  logic                       valid;
  logic                       ready;
  logic [css_pkg::ChanW-1:0]  in_red;
  logic [css_pkg::ChanW-1:0]  in_green;
  logic [css_pkg::ChanW-1:0]  in_blue;
  logic [css_pkg::ChanW-1:0]  in_alpha;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

// File: hw/rtl/css_out_if.sv
// Request channel that carries one corrected RGBA pixel.
// Depends on css_pkg for the channel width.
interface css_out_if;
  logic                       valid;
  logic                       ready;
  logic [css_pkg::ChanW-1:0]  out_red;
  logic [css_pkg::ChanW-1:0]  out_green;
  logic [css_pkg::ChanW-1:0]  out_blue;
  logic [css_pkg::ChanW-1:0]  out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

// File: hw/rtl/css_chan.sv
// One color channel of the gain path: split multiply, then exact add,
// floor and saturate. Depends on css_pkg.
module css_chan (
  input  logic                               clk_i,
  input  css_pkg::css_adv_t                  adv_i,
  input  logic [css_pkg::ChanW-1:0]          chan_i,
  input  logic [css_pkg::SpillW-1:0]         spill_i,
  input  logic signed [css_pkg::GsumW-1:0]   gain_i,
  output logic [css_pkg::ChanW-1:0]          res_o
);
  import css_pkg::*;

  logic [ChanW-1:0]        chan_q;
  logic signed [PartW-1:0] p_hi_q, p_hi_d;
  logic signed [PartW-1:0] p_lo_q, p_lo_d;
  logic signed [GsumW-1:0] hi_s, lo_s;
  logic signed [63:0]      sum;
  logic [ChanW-1:0]        res_q, res_d;

  // Spill is split in two 20-bit halves so each multiply stays narrow.
  assign hi_s   = {1'b0, spill_i[SpillW-1:SplitW]};
  assign lo_s   = {1'b0, spill_i[SplitW-1:0]};
  assign p_hi_d = PartW'(hi_s) * PartW'(gain_i);
  assign p_lo_d = PartW'(lo_s) * PartW'(gain_i);

  always_ff @(posedge clk_i) begin
    if (adv_i.ld3) begin
      chan_q <= chan_i;
      p_hi_q <= p_hi_d;
      p_lo_q <= p_lo_d;
    end
  end

  always_comb begin
    sum = $signed({12'd0, chan_q, 44'd0}) + (64'(p_hi_q) <<< SplitW) + 64'(p_lo_q);
    if (sum[63]) begin
      res_d = '0;
    end else if (|sum[62:ProdFrac+ChanW]) begin
      res_d = '1;
    end else begin
      res_d = sum[ProdFrac+ChanW-1:ProdFrac];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld4) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: hw/rtl/chroma_spill_suppressor.sv
// Chroma spill suppressor: a four-stage pipeline that takes one RGBA pixel
// per clock while the sink keeps up and returns one corrected pixel for each.
// Stage one forms the red-times-mix and other-times-factor products, stage
// two subtracts them from the key channel and clamps the spill at zero,
// stage three multiplies the spill by each channel's gain plus brightness in
// two narrow partial products and forms the inverted-spill alpha, and stage
// four adds, floors and saturates into the output register. A pixel can
// enter in every cycle while the sink takes results, for a sustained rate of
// one pixel per clock. When the sink stalls, bubbles in the pipe are
// squeezed out before the input request is held.
// Derived weights (saturated mix, the factor (1-mix)(1-expand) and the
// per-channel gain sums) are registered from the configuration, so a new
// setting applies to pixels accepted from the cycle after its write.
// Depends on css_pkg, css_in_if, css_out_if and css_chan.
module chroma_spill_suppressor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  css_in_if.sink                         s_pix_i,
  css_out_if.source                      m_pix_o,
  input  logic                           cfg_we_i,
  input  logic [css_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [css_pkg::CfgDataW-1:0]   cfg_data_i
);
  import css_pkg::*;

  // Configuration registers.
  logic                      screen_q;
  logic                      alpha_en_q;
  logic [WeightW-1:0]        mix_q;
  logic [WeightW-1:0]        expand_q;
  logic [GainW-1:0]          rgain_q, ggain_q, bgain_q;
  logic [BrightW-1:0]        bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_q   <= 1'b0;
      alpha_en_q <= 1'b0;
      mix_q      <= 17'd32768;
      expand_q   <= '0;
      rgain_q    <= '0;
      ggain_q    <= 20'hFF000;
      bgain_q    <= '0;
      bright_q   <= '0;
    end else if (cfg_we_i) begin
      case (css_reg_e'(cfg_idx_i))
        REG_SCREEN_TYPE:  screen_q   <= cfg_data_i[0];
        REG_ALPHA_ENABLE: alpha_en_q <= cfg_data_i[0];
        REG_SPILL_MIX:    mix_q      <= cfg_data_i[WeightW-1:0];
        REG_SPILL_EXPAND: expand_q   <= cfg_data_i[WeightW-1:0];
        REG_RED_GAIN:     rgain_q    <= cfg_data_i[GainW-1:0];
        REG_GREEN_GAIN:   ggain_q    <= cfg_data_i[GainW-1:0];
        REG_BLUE_GAIN:    bgain_q    <= cfg_data_i[GainW-1:0];
        REG_BRIGHT_GAIN:  bright_q   <= cfg_data_i[BrightW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Derived weights. Mix and expand above one saturate to one. The weights
  // are taken from the values the registers hold after this edge, so the
  // saturated mix and the factor are already current for a pixel accepted
  // in the cycle right after a write.
  logic [WeightW-1:0]      mix_nx, exp_nx;
  logic [WeightW-1:0]      mix_sat_q, mix_sat_d;
  logic [WeightW-1:0]      exp_sat, one_m_mix, one_m_exp;
  logic [FactorW-1:0]      factor_q, factor_d;
  logic signed [GsumW-1:0] rsum_q, gsum_q, bsum_q;
  logic signed [GsumW-1:0] rsum_d, gsum_d, bsum_d;
  logic [GsumW-1:0]        bright_ext;

  assign mix_nx     = (cfg_we_i && (css_reg_e'(cfg_idx_i) == REG_SPILL_MIX))
                    ? cfg_data_i[WeightW-1:0] : mix_q;
  assign exp_nx     = (cfg_we_i && (css_reg_e'(cfg_idx_i) == REG_SPILL_EXPAND))
                    ? cfg_data_i[WeightW-1:0] : expand_q;
  assign mix_sat_d  = (mix_nx > Q16One) ? Q16One : mix_nx;
  assign exp_sat    = (exp_nx > Q16One) ? Q16One : exp_nx;
  assign one_m_mix  = Q16One - mix_sat_d;
  assign one_m_exp  = Q16One - exp_sat;
  assign factor_d   = FactorW'(one_m_mix) * FactorW'(one_m_exp);
  assign bright_ext = {{(GsumW-BrightW){bright_q[BrightW-1]}}, bright_q};
  assign rsum_d     = $signed({rgain_q[GainW-1], rgain_q} + bright_ext);
  assign gsum_d     = $signed({ggain_q[GainW-1], ggain_q} + bright_ext);
  assign bsum_d     = $signed({bgain_q[GainW-1], bgain_q} + bright_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_sat_q <= 17'd32768;
      factor_q  <= 33'h080000000;
      rsum_q    <= '0;
      gsum_q    <= -21'sd4096;
      bsum_q    <= '0;
    end else begin
      mix_sat_q <= mix_sat_d;
      factor_q  <= factor_d;
      rsum_q    <= rsum_d;
      gsum_q    <= gsum_d;
      bsum_q    <= bsum_d;
    end
  end

  // Stage valid bits and the backward ready chain. A stage loads when it is
  // empty or when the stage after it moves on.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_pix_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_pix_i.ready = rdy1;
  assign m_pix_o.valid = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_pix_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: pick key and other channel, form both weighted products.
  logic [ChanW-1:0]       key_d, oth_d;
  logic [ChanW-1:0]       s1_key_q, s1_r_q, s1_g_q, s1_b_q, s1_a_q;
  logic [24:0]            s1_pmix_q, s1_pmix_d;
  logic [SpillW-1:0]      s1_poth_q, s1_poth_d;

  assign key_d = (screen_q == ScreenBlue) ? s_pix_i.in_blue  : s_pix_i.in_green;
  assign oth_d = (screen_q == ScreenBlue) ? s_pix_i.in_green : s_pix_i.in_blue;
  assign s1_pmix_d = 25'(s_pix_i.in_red) * 25'(mix_sat_q);
  assign s1_poth_d = SpillW'(41'(oth_d) * 41'(factor_q));

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_key_q  <= key_d;
      s1_r_q    <= s_pix_i.in_red;
      s1_g_q    <= s_pix_i.in_green;
      s1_b_q    <= s_pix_i.in_blue;
      s1_a_q    <= s_pix_i.in_alpha;
      s1_pmix_q <= s1_pmix_d;
      s1_poth_q <= s1_poth_d;
    end
  end

  // Stage 2: spill in channel units with 32 fraction bits, clamped at zero.
  logic signed [41:0] diff;
  logic [SpillW-1:0]  s2_spill_q, s2_spill_d;
  logic [ChanW-1:0]   s2_r_q, s2_g_q, s2_b_q, s2_a_q;

  assign diff = $signed(42'({s1_key_q, 32'd0}))
              - $signed(42'({s1_pmix_q, 16'd0}))
              - $signed(42'(s1_poth_q));
  assign s2_spill_d = diff[41] ? '0 : diff[SpillW-1:0];

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_spill_q <= s2_spill_d;
      s2_r_q     <= s1_r_q;
      s2_g_q     <= s1_g_q;
      s2_b_q     <= s1_b_q;
      s2_a_q     <= s1_a_q;
    end
  end

  // Stage 3 and 4 for alpha: 255 minus spill, floored. Spill never exceeds
  // 255 in channel units, so the difference cannot wrap.
  logic [SpillW-1:0] inv_spill;
  logic [ChanW-1:0]  s3_alpha_q, s3_alpha_d;
  logic [ChanW-1:0]  s4_alpha_q;

  assign inv_spill  = {8'hFF, 32'd0} - s2_spill_q;
  assign s3_alpha_d = alpha_en_q ? inv_spill[SpillW-1:SpillFrac] : s2_a_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_alpha_q <= s3_alpha_d;
    end
    if (rdy4) begin
      s4_alpha_q <= s3_alpha_q;
    end
  end

  // Stages 3 and 4 for the color channels.
  css_adv_t adv;
  assign adv.ld3 = rdy3;
  assign adv.ld4 = rdy4;

  css_chan u_red (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .chan_i  (s2_r_q),
    .spill_i (s2_spill_q),
    .gain_i  (rsum_q),
    .res_o   (m_pix_o.out_red)
  );

  css_chan u_green (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .chan_i  (s2_g_q),
    .spill_i (s2_spill_q),
    .gain_i  (gsum_q),
    .res_o   (m_pix_o.out_green)
  );

  css_chan u_blue (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .chan_i  (s2_b_q),
    .spill_i (s2_spill_q),
    .gain_i  (bsum_q),
    .res_o   (m_pix_o.out_blue)
  );

  assign m_pix_o.out_alpha = s4_alpha_q;

endmodule

// File: verif/chroma_spill_suppressor_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the chroma spill suppressor pixel pipeline.
// Depends on css_pkg, css_in_if, css_out_if and the chroma_spill_suppressor RTL.
module chroma_spill_suppressor_test;
  import css_pkg::*;

  // One RGBA pixel as it travels on either request channel. Red sits in the top byte.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } pixel_t;

  // Our own copy of the block's registers, kept at the widths the block stores.
  typedef struct {
    logic                      blue_screen;
    logic                      alpha_en;
    logic [WeightW-1:0]        mix;
    logic [WeightW-1:0]        expand;
    logic signed [GainW-1:0]   red_gain;
    logic signed [GainW-1:0]   green_gain;
    logic signed [GainW-1:0]   blue_gain;
    logic signed [BrightW-1:0] bright;
  } suppress_cfg_t;

  // Ways the output side holds off the block.
  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_PATTERN,
    STALL_LONG
  } stall_mode_e;

  localparam longint WeightOne   = longint'(Q16One);
  localparam int     DrainLimit  = 4000;
  localparam int     PrintLimit  = 40;
  localparam int     RandPhases  = 10;
  localparam int     PhaseItems  = 85;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  css_in_if  pix_in ();
  css_out_if pix_out ();

  chroma_spill_suppressor uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_pix_i    (pix_in),
    .m_pix_o    (pix_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  suppress_cfg_t active_cfg;
  pixel_t        corrected_q[$];  // predicted output pixels, oldest first

  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned reg_writes;
  int unsigned settings_used;

  // Sender burst shaping and receiver stall control, changed per phase.
  int unsigned burst_left;
  int unsigned gap_max;
  stall_mode_e stall_mode;
  logic [15:0] ready_pattern;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the pipeline wedges. The slowest legal run is a few hundred
  // microseconds, so this leaves a wide margin.
  initial begin
    #5_000_000;
    $display("chroma_spill_suppressor_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Everything is done exactly in 64-bit integers: the spill carries
  // 32 fraction bits and spill times gain carries 44. Floors go toward minus
  // infinity and then clamp to the 8-bit channel range.
  // ---------------------------------------------------------------------------
  function automatic logic [ChanW-1:0] floor_clamp(longint v, int unsigned frac);
    longint q;
    if (v < 0) return '0;
    q = v >>> frac;
    return (q > 255) ? 8'd255 : q[ChanW-1:0];
  endfunction

  function automatic logic [ChanW-1:0] add_spill(logic [ChanW-1:0] chan, longint spill,
                                                  longint gain);
    return floor_clamp((longint'(chan) <<< ProdFrac) + spill * gain, ProdFrac);
  endfunction

  function automatic pixel_t suppress_spill(pixel_t px, suppress_cfg_t c);
    longint mix_w, exp_w, factor, key, other, spill, bright;
    pixel_t res;
    // Weights above one are treated as exactly one.
    mix_w  = (c.mix > Q16One) ? WeightOne : longint'(c.mix);
    exp_w  = (c.expand > Q16One) ? WeightOne : longint'(c.expand);
    factor = (WeightOne - mix_w) * (WeightOne - exp_w);
    // Bluescreen swaps the roles of green and blue; red always takes the mix weight.
    key    = c.blue_screen ? longint'(px.blue) : longint'(px.green);
    other  = c.blue_screen ? longint'(px.green) : longint'(px.blue);
    spill  = (key <<< SpillFrac) - (longint'(px.red) * mix_w * WeightOne + other * factor);
    if (spill < 0) spill = 0;
    bright    = longint'(c.bright);
    res.red   = add_spill(px.red, spill, longint'(c.red_gain) + bright);
    res.green = add_spill(px.green, spill, longint'(c.green_gain) + bright);
    res.blue  = add_spill(px.blue, spill, longint'(c.blue_gain) + bright);
    res.alpha = c.alpha_en ? floor_clamp((longint'(255) <<< SpillFrac) - spill, SpillFrac)
                           : px.alpha;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PrintLimit) $display("%0t ns: MISMATCH %s", $time, what);
  endtask

  task automatic check_pixel(pixel_t got);
    pixel_t want;
    logic [ChanW-1:0] g, w;
    string names [4];
    names = '{"red", "green", "blue", "alpha"};
    if (corrected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected output pixel %h", got));
      return;
    end
    want = corrected_q.pop_front();
    for (int k = 0; k < 4; k++) begin
      g = got[8*(3-k) +: 8];
      w = want[8*(3-k) +: 8];
      if (g !== w)
        report_mismatch($sformatf("output pixel %0d %s got %0d want %0d",
                                  pixels_checked, names[k], g, w));
    end
    pixels_checked++;
  endtask

  // Both channels are watched from one process at each rising edge. The output is
  // checked before the input request of the same edge is predicted, so a result can
  // never be matched against a pixel that entered in the same cycle.
  initial begin
    forever begin
      @(posedge clk_i);
      if (pix_out.valid && pix_out.ready)
        check_pixel({pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                     pix_out.out_alpha});
      if (pix_in.valid && pix_in.ready) begin
        corrected_q.push_back(suppress_spill({pix_in.in_red, pix_in.in_green,
                                              pix_in.in_blue, pix_in.in_alpha},
                                             active_cfg));
        pixels_sent++;
      end
    end
  end

  // Output ready. Each mode gives a different rhythm of back-pressure; the long mode
  // holds ready low, and then high, for random stretches so the pipe fills up.
  initial begin
    int unsigned hold;
    logic        level;
    pix_out.ready = 1'b0;
    hold  = 0;
    level = 1'b0;
    forever begin
      @(negedge clk_i);
      case (stall_mode)
        STALL_NONE: begin
          pix_out.ready <= 1'b1;
        end
        STALL_COIN: begin
          pix_out.ready <= 1'($urandom_range(0, 1));
        end
        STALL_PATTERN: begin
          pix_out.ready <= ready_pattern[0];
          ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        end
        default: begin
          if (hold == 0) begin
            level = ~level;
            hold  = level ? $urandom_range(1, 24) : $urandom_range(1, 24);
          end
          hold--;
          pix_out.ready <= level;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Register write through the plain write port. The shadow copy is updated at the
  // same time; writes only happen while nothing is in flight.
  task automatic write_reg(css_reg_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_SCREEN_TYPE:  active_cfg.blue_screen = (data[0] == ScreenBlue);
      REG_ALPHA_ENABLE: active_cfg.alpha_en    = data[0];
      REG_SPILL_MIX:    active_cfg.mix         = data[WeightW-1:0];
      REG_SPILL_EXPAND: active_cfg.expand      = data[WeightW-1:0];
      REG_RED_GAIN:     active_cfg.red_gain    = data[GainW-1:0];
      REG_GREEN_GAIN:   active_cfg.green_gain  = data[GainW-1:0];
      REG_BLUE_GAIN:    active_cfg.blue_gain   = data[GainW-1:0];
      REG_BRIGHT_GAIN:  active_cfg.bright      = data[BrightW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Sends one pixel request and returns at the edge where it is accepted. A new burst
  // may open with a gap of random length, during which the payload carries noise.
  task automatic send_pixel(pixel_t px);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) gap = $urandom_range(0, gap_max);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      {pix_in.in_red, pix_in.in_green, pix_in.in_blue, pix_in.in_alpha} <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    pix_in.valid <= 1'b1;
    {pix_in.in_red, pix_in.in_green, pix_in.in_blue, pix_in.in_alpha} <= px;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
  endtask

  // Drops the input request and waits until every predicted pixel has come out, so
  // the registers can be rewritten safely. Every pixel yields exactly one result,
  // so an empty queue means the pipe is empty.
  task automatic settle();
    int unsigned waited;
    @(negedge clk_i);
    pix_in.valid <= 1'b0;
    burst_left = 0;
    waited = 0;
    while (corrected_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  function automatic pixel_t make_pixel(int r, int g, int b, int a);
    return {8'(r), 8'(g), 8'(b), 8'(a)};
  endfunction

  function automatic logic [ChanW-1:0] jitter(int base);
    int v;
    v = base + int'($urandom_range(0, 8)) - 4;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // Random pixels: a mix of plain noise, pixels where the key channel dominates (the
  // interesting spill range), and near-gray pixels that sit close to zero spill.
  function automatic pixel_t random_pixel(logic blue_screen);
    pixel_t px;
    int unsigned k;
    logic [ChanW-1:0] key, other;
    px = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5, 6, 7: begin
        k      = $urandom_range(96, 255);
        key    = 8'(k);
        other  = 8'($urandom_range(0, k));
        px.red = 8'($urandom_range(0, k));
        if (blue_screen) begin
          px.blue  = key;
          px.green = other;
        end else begin
          px.green = key;
          px.blue  = other;
        end
      end
      default: begin
        k        = $urandom_range(0, 255);
        px.red   = jitter(k);
        px.green = jitter(k);
        px.blue  = jitter(k);
      end
    endcase
    return px;
  endfunction

  // Weight value for mix or expand. Out-of-range values exercise the saturation to
  // one, and raw 20-bit data checks that only the low 17 bits are kept.
  function automatic logic [CfgDataW-1:0] pick_weight(bit extremes);
    case (extremes ? $urandom_range(0, 5) : $urandom_range(4, 12))
      0:       return '0;
      1:       return CfgDataW'(Q16One);
      2:       return CfgDataW'($urandom_range(65537, 131071));
      3:       return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(0, 65536));
    endcase
  endfunction

  // Signed gain of the given stored width; normally within the useful range, with
  // the full-width extremes and raw data mixed in.
  function automatic logic [CfgDataW-1:0] pick_gain(bit extremes, int unsigned lim,
                                                     int unsigned bits);
    int v;
    case (extremes ? $urandom_range(0, 5) : $urandom_range(3, 12))
      0:       v = -(1 << (bits - 1));
      1:       v = (1 << (bits - 1)) - 1;
      2:       v = int'($urandom);
      default: v = int'($urandom_range(0, 2 * lim)) - int'(lim);
    endcase
    return v[CfgDataW-1:0];
  endfunction

  task automatic program_random_settings(bit extremes);
    write_reg(REG_SCREEN_TYPE, CfgDataW'($urandom_range(0, 1)));
    write_reg(REG_ALPHA_ENABLE, CfgDataW'($urandom_range(0, 1)));
    write_reg(REG_SPILL_MIX, pick_weight(extremes));
    write_reg(REG_SPILL_EXPAND, pick_weight(extremes));
    write_reg(REG_RED_GAIN, pick_gain(extremes, 409600, GainW));
    write_reg(REG_GREEN_GAIN, pick_gain(extremes, 409600, GainW));
    write_reg(REG_BLUE_GAIN, pick_gain(extremes, 409600, GainW));
    write_reg(REG_BRIGHT_GAIN, pick_gain(extremes, 40960, BrightW));
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Pixels straight after reset: greenscreen, half mix, green pulled down by the
  // full spill, alpha passed through.
  task automatic test_reset_defaults();
    settings_used++;
    send_pixel(make_pixel(0, 255, 0, 77));
    send_pixel(make_pixel(0, 0, 0, 0));
    send_pixel(make_pixel(255, 255, 255, 255));
    send_pixel(make_pixel(100, 200, 50, 128));
    settle();
  endtask

  // Directed corners of the settings and of the pixel fields.
  task automatic test_extreme_settings();
    // Zero mix and expand: the factor is one, so spill is key minus the other
    // channel. Gains at the ends of their full signed width, alpha from spill.
    write_reg(REG_SCREEN_TYPE, '0);
    write_reg(REG_ALPHA_ENABLE, 20'd1);
    write_reg(REG_SPILL_MIX, '0);
    write_reg(REG_SPILL_EXPAND, '0);
    write_reg(REG_RED_GAIN, 20'h7FFFF);
    write_reg(REG_GREEN_GAIN, 20'h80000);
    write_reg(REG_BLUE_GAIN, '0);
    write_reg(REG_BRIGHT_GAIN, 20'h0FFFF);
    settings_used++;
    send_pixel(make_pixel(0, 255, 0, 200));
    send_pixel(make_pixel(0, 255, 255, 13));
    send_pixel(make_pixel(255, 255, 255, 0));
    send_pixel(make_pixel(0, 0, 0, 255));
    settle();

    // Mix and expand written above one must saturate to one. Bluescreen, with the
    // most negative brightness and both colour gains swapped to the other end.
    write_reg(REG_SCREEN_TYPE, 20'(ScreenBlue));
    write_reg(REG_SPILL_MIX, 20'h1FFFF);
    write_reg(REG_SPILL_EXPAND, 20'h1FFFF);
    write_reg(REG_RED_GAIN, 20'h80000);
    write_reg(REG_BLUE_GAIN, 20'h7FFFF);
    write_reg(REG_BRIGHT_GAIN, 20'h10000);
    settings_used++;
    send_pixel(make_pixel(255, 0, 255, 9));
    send_pixel(make_pixel(0, 0, 255, 128));
    send_pixel(make_pixel(40, 128, 255, 255));
    settle();

    // Exactly one for both weights, gains at the edges of the useful range, and
    // alpha disabled so it passes through untouched.
    write_reg(REG_SCREEN_TYPE, '0);
    write_reg(REG_ALPHA_ENABLE, '0);
    write_reg(REG_SPILL_MIX, 20'(Q16One));
    write_reg(REG_SPILL_EXPAND, 20'(Q16One));
    write_reg(REG_RED_GAIN, 20'(409600));
    write_reg(REG_GREEN_GAIN, 20'(-409600));
    write_reg(REG_BLUE_GAIN, 20'(409600));
    write_reg(REG_BRIGHT_GAIN, 20'(40960));
    settings_used++;
    send_pixel(make_pixel(0, 255, 0, 77));
    send_pixel(make_pixel(128, 200, 90, 1));
    settle();

    // No mix with full expand: the factor is zero and the spill is the whole key.
    write_reg(REG_SPILL_MIX, '0);
    write_reg(REG_ALPHA_ENABLE, 20'd1);
    settings_used++;
    send_pixel(make_pixel(255, 255, 255, 3));
    send_pixel(make_pixel(0, 1, 0, 254));
    settle();
  endtask

  // Random pixels under a series of random settings. Each phase also picks its own
  // sender gaps and receiver stall rhythm; one phase runs with no idling at all so
  // the pipe is exercised at full rate.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RandPhases; phase++) begin
      program_random_settings(phase % 3 == 0);
      ready_pattern = 16'($urandom) | 16'h0001;
      if (phase == 1) begin
        gap_max    = 0;
        stall_mode = STALL_NONE;
      end else begin
        case ($urandom_range(0, 2))
          0:       gap_max = 0;
          1:       gap_max = 2;
          default: gap_max = 8;
        endcase
        stall_mode = stall_mode_e'($urandom_range(0, 3));
      end
      for (int n = 0; n < PhaseItems; n++)
        send_pixel(random_pixel(active_cfg.blue_screen));
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_SCREEN_TYPE;
    cfg_data     = '0;
    pix_in.valid = 1'b0;
    {pix_in.in_red, pix_in.in_green, pix_in.in_blue, pix_in.in_alpha} = '0;

    // Register values after reset.
    active_cfg.blue_screen = 1'b0;
    active_cfg.alpha_en    = 1'b0;
    active_cfg.mix         = 17'd32768;
    active_cfg.expand      = '0;
    active_cfg.red_gain    = '0;
    active_cfg.green_gain  = -20'sd4096;
    active_cfg.blue_gain   = '0;
    active_cfg.bright      = '0;

    mismatches     = 0;
    pixels_sent    = 0;
    pixels_checked = 0;
    reg_writes     = 0;
    settings_used  = 0;
    burst_left     = 0;
    gap_max        = 3;
    stall_mode     = STALL_COIN;
    ready_pattern  = 16'hB5A3;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_extreme_settings();
    test_random_traffic();

    // Everything has been sent and drained; keep the clock running so any stray output
    // can show before closing.
    repeat (16) @(posedge clk_i);
    if (corrected_q.size() != 0)
      report_mismatch($sformatf("%0d output pixels never arrived", corrected_q.size()));

    $display("summary: %0d pixels sent, %0d checked, %0d register writes, %0d settings",
             pixels_sent, pixels_checked, reg_writes, settings_used);
    $display("summary: both screen modes, weight saturation, full-width gains, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("chroma_spill_suppressor_test: clean");
    end else begin
      $display("chroma_spill_suppressor_test: errors");
    end
    $finish;
  end

endmodule

// File: chroma_spill_suppressor.f
hw/rtl/css_pkg.sv
hw/rtl/css_in_if.sv
hw/rtl/css_out_if.sv
hw/rtl/css_chan.sv
hw/rtl/chroma_spill_suppressor.sv
verif/chroma_spill_suppressor_test.sv
